>>> design/qsu_pkg.sv
`default_nettype none
package qsu_pkg;

   // scan phases
   localparam logic [2:0] PH_SEEK = 3'd0;
   localparam logic [2:0] PH_BODY = 3'd1;
   localparam logic [2:0] PH_ESC  = 3'd2;
   localparam logic [2:0] PH_HEX  = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_UNTERM  = 3'd1;
   localparam logic [2:0] ST_BADESC  = 3'd2;
   localparam logic [2:0] ST_BADHEX  = 3'd3;
   localparam logic [2:0] ST_NOQUOTE = 3'd4;

   // character codes
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;

   // queue depth in packets
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = 1;
   localparam int unsigned QCNT_W      = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_final;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_status;
      logic [2:0] status_code;
      logic       run_end;
   } rsp_word_type;

   // all results caused by one input word
   typedef struct packed {
      logic [1:0]      nbytes;
      logic [2:0][7:0] bytes;
      logic            has_status;
      logic [2:0]      code;
   } pkt_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      pkt_type pkt;
   } head_type;

   // hex digit decode: bit 4 flags a valid digit
   function automatic logic [4:0] nibble_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> design/qsu_front.sv
`default_nettype none
module qsu_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire qsu_pkg::req_word_type req_word,
   input  wire logic                 accept,
   output qsu_pkg::pkt_type          pkt,
   output logic                      pkt_nonempty
);
   import qsu_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic        quote_single_ff, quote_single_in;
   logic [15:0] hex_acc_ff, hex_acc_in;
   logic [1:0]  hex_cnt_ff, hex_cnt_in;

   logic [7:0]  c;
   logic [4:0]  dig;
   logic [15:0] cp;
   logic [7:0]  close_quote;

   // classify one word and build its result packet
   always_comb begin
      c               = req_word.data_byte;
      dig             = nibble_decode(c);
      cp              = {hex_acc_ff[11:0], dig[3:0]};
      close_quote     = quote_single_ff ? CH_SQUOTE : CH_DQUOTE;
      phase_in        = phase_ff;
      quote_single_in = quote_single_ff;
      hex_acc_in      = hex_acc_ff;
      hex_cnt_in      = hex_cnt_ff;
      pkt             = '0;

      unique case (phase_ff)
         PH_SEEK: begin
            if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
               // skip whitespace
            end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
               quote_single_in = (c == CH_SQUOTE);
               phase_in        = PH_BODY;
            end else begin
               pkt.has_status = 1'b1;
               pkt.code       = ST_NOQUOTE;
               phase_in       = PH_DONE;
            end
         end
         PH_BODY: begin
            if (c == close_quote) begin
               pkt.has_status = 1'b1;
               pkt.code       = ST_OK;
               phase_in       = PH_DONE;
            end else if (c == CH_BSLASH) begin
               phase_in = PH_ESC;
            end else begin
               pkt.nbytes   = 2'd1;
               pkt.bytes[0] = c;
            end
         end
         PH_ESC: begin
            phase_in   = PH_BODY;
            pkt.nbytes = 2'd1;
            case (c) inside
               CH_DQUOTE, CH_SQUOTE, CH_BSLASH, CH_SLASH: pkt.bytes[0] = c;
               CH_LOW_B: pkt.bytes[0] = 8'h08;
               CH_LOW_F: pkt.bytes[0] = 8'h0C;
               CH_LOW_N: pkt.bytes[0] = 8'h0A;
               CH_LOW_R: pkt.bytes[0] = 8'h0D;
               CH_LOW_T: pkt.bytes[0] = 8'h09;
               CH_LOW_U: begin
                  pkt.nbytes = 2'd0;
                  hex_acc_in = 16'd0;
                  hex_cnt_in = 2'd0;
                  phase_in   = PH_HEX;
               end
               default: begin
                  pkt.nbytes     = 2'd0;
                  pkt.has_status = 1'b1;
                  pkt.code       = ST_BADESC;
                  phase_in       = PH_DONE;
               end
            endcase
         end
         PH_HEX: begin
            if (!dig[4]) begin
               pkt.has_status = 1'b1;
               pkt.code       = ST_BADHEX;
               phase_in       = PH_DONE;
            end else begin
               hex_acc_in = cp;
               if (hex_cnt_ff == 2'd3) begin
                  hex_cnt_in = 2'd0;
                  phase_in   = PH_BODY;
                  // encode the code point as UTF-8
                  if (cp <= 16'h007F) begin
                     pkt.nbytes   = 2'd1;
                     pkt.bytes[0] = cp[7:0];
                  end else if (cp <= 16'h07FF) begin
                     pkt.nbytes   = 2'd2;
                     pkt.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
                     pkt.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
                  end else begin
                     pkt.nbytes   = 2'd3;
                     pkt.bytes[0] = 8'hE0 | {4'h0, cp[15:12]};
                     pkt.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
                     pkt.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
                  end
               end else begin
                  hex_cnt_in = hex_cnt_ff + 2'd1;
               end
            end
         end
         default: begin
            // done: drop the word
         end
      endcase

      // close the buffer on the final word
      if (req_word.is_final) begin
         case (phase_in) inside
            PH_SEEK: begin
               pkt.has_status = 1'b1;
               pkt.code       = ST_NOQUOTE;
            end
            PH_BODY, PH_ESC, PH_HEX: begin
               pkt.has_status = 1'b1;
               pkt.code       = ST_UNTERM;
            end
            default: ;
         endcase
         phase_in        = PH_SEEK;
         quote_single_in = 1'b0;
         hex_acc_in      = 16'd0;
         hex_cnt_in      = 2'd0;
      end

      pkt_nonempty = (pkt.nbytes != 2'd0) || pkt.has_status;
   end

   // advance scan state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SEEK;
         quote_single_ff <= 1'b0;
         hex_acc_ff      <= 16'd0;
         hex_cnt_ff      <= 2'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         quote_single_ff <= quote_single_in;
         hex_acc_ff      <= hex_acc_in;
         hex_cnt_ff      <= hex_cnt_in;
      end
   end

endmodule
`default_nettype wire

>>> design/qsu_queue.sv
`default_nettype none
module qsu_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire qsu_pkg::pkt_type push_pkt,
   input  wire logic             pop,
   output logic                  full,
   output qsu_pkg::head_type     head
);
   import qsu_pkg::*;

   pkt_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.pkt   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // store packets
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_pkt;
      end
   end

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid) else $error("pop from empty queue");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("pointers disagree with empty count");

endmodule
`default_nettype wire

>>> design/qsu_back.sv
`default_nettype none
module qsu_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire qsu_pkg::head_type  head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output qsu_pkg::rsp_word_type   rsp_word
);
   import qsu_pkg::*;

   logic         out_valid_ff;
   rsp_word_type out_ff, out_in;
   logic [1:0]   idx_ff;
   logic [2:0]   total;
   logic         is_last;
   logic         load;

   assign total   = {1'b0, head.pkt.nbytes} + {2'b00, head.pkt.has_status};
   assign is_last = ({1'b0, idx_ff} + 3'd1) == total;
   assign load    = head.valid && (!out_valid_ff || !rsp_stall);
   assign pop     = load && is_last;

   // pick the result at the current index
   always_comb begin
      out_in         = '0;
      out_in.run_end = is_last;
      if (idx_ff < head.pkt.nbytes) begin
         out_in.out_byte = head.pkt.bytes[idx_ff];
      end else begin
         out_in.is_status   = 1'b1;
         out_in.status_code = head.pkt.code;
      end
   end

   // hold the output word until taken
   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (load) begin
            idx_ff <= is_last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   a_idx_in_packet: assert property (@(posedge clock) disable iff (reset)
      head.valid |-> ({1'b0, idx_ff} < total)) else $error("index past packet end");
   a_idx_zero_on_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> (idx_ff == 2'd0)) else $error("index not cleared after pop");
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.is_status) |-> rsp_word.run_end)
      else $error("status word not last of its run");

endmodule
`default_nettype wire

>>> design/quoted_string_unescape_utf8_unit.sv
// Each result word is registered in the queue and then in the output register.
// Throughput: one input word per cycle while the queue has room; the back end sends
// one result word per cycle while rsp_stall is low, so a word that yields k results
// (up to four, for a three-byte UTF-8 escape plus status) holds the output side for k
// words, absorbed by a two-packet queue. Reset: synchronous, active high; returns the
// scanner to seeking an opening quote and empties the queue and output register.
`default_nettype none
module quoted_string_unescape_utf8_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire qsu_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output qsu_pkg::rsp_word_type      rsp_word
);
   import qsu_pkg::*;

   logic     accept;
   logic     full;
   logic     pop;
   logic     pkt_nonempty;
   pkt_type  pkt;
   head_type head;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   // classify incoming words
   qsu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_word     (req_word),
      .accept       (accept),
      .pkt          (pkt),
      .pkt_nonempty (pkt_nonempty)
   );

   // buffer result packets
   qsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept && pkt_nonempty),
      .push_pkt (pkt),
      .pop      (pop),
      .full     (full),
      .head     (head)
   );

   // serialize packets into result words
   qsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

>>> test/quoted_string_unescape_checker.sv
`timescale 1ns / 100ps
module quoted_string_unescape_checker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire qsu_pkg::req_word_type req_word,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire qsu_pkg::rsp_word_type rsp_word,
   output int unsigned                fail_count,
   output int unsigned                pending_count
);
   import qsu_pkg::*;

   localparam logic [7:0] CH_BS      = 8'h08;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_FF      = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_DIGIT0  = 8'h30;
   localparam logic [7:0] CH_DIGIT9  = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;

   // scanner state of the predictor
   logic [2:0]   scan_phase      = PH_SEEK;
   logic         quote_is_single = 1'b0;
   logic [15:0]  hex_accum       = '0;
   logic [1:0]   hex_digits_seen = '0;

   rsp_word_type decoded_rsp[$];
   rsp_word_type word_results[$];
   int unsigned  mismatches = 0;

   task automatic clear_scan();
      scan_phase      = PH_SEEK;
      quote_is_single = 1'b0;
      hex_accum       = '0;
      hex_digits_seen = '0;
   endtask

   task automatic emit_byte(input logic [7:0] b);
      rsp_word_type r;
      r          = '0;
      r.out_byte = b;
      word_results.insert(word_results.size(), r);
   endtask

   // a status closes the string; everything up to the final word is ignored
   task automatic emit_status(input logic [2:0] code);
      rsp_word_type r;
      r             = '0;
      r.is_status   = 1'b1;
      r.status_code = code;
      word_results.insert(word_results.size(), r);
      scan_phase = PH_DONE;
   endtask

   // advance the scanner by one input word and queue the results it yields
   task automatic unescape_word(input req_word_type w);
      logic [7:0]   c;
      logic [3:0]   nib;
      logic         nib_ok;
      rsp_word_type r;
      c = w.data_byte;
      word_results.delete();
      case (scan_phase)
         PH_SEEK: begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
               // skip leading whitespace
            end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
               quote_is_single = (c == CH_SQUOTE);
               scan_phase      = PH_BODY;
            end else begin
               emit_status(ST_NOQUOTE);
            end
         end
         PH_BODY: begin
            if (c == (quote_is_single ? CH_SQUOTE : CH_DQUOTE)) begin
               emit_status(ST_OK);
            end else if (c == CH_BSLASH) begin
               scan_phase = PH_ESC;
            end else begin
               emit_byte(c);
            end
         end
         PH_ESC: begin
            scan_phase = PH_BODY;
            case (c)
               CH_DQUOTE, CH_SQUOTE, CH_BSLASH, CH_SLASH: emit_byte(c);
               CH_LOW_B: emit_byte(CH_BS);
               CH_LOW_F: emit_byte(CH_FF);
               CH_LOW_N: emit_byte(CH_LF);
               CH_LOW_R: emit_byte(CH_CR);
               CH_LOW_T: emit_byte(CH_TAB);
               CH_LOW_U: begin
                  hex_accum       = '0;
                  hex_digits_seen = '0;
                  scan_phase      = PH_HEX;
               end
               default: emit_status(ST_BADESC);
            endcase
         end
         PH_HEX: begin
            nib_ok = 1'b1;
            nib    = '0;
            if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
               nib = 4'(c - CH_DIGIT0);
            end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
               nib = 4'(c - CH_LOWER_A + 8'd10);
            end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
               nib = 4'(c - CH_UPPER_A + 8'd10);
            end else begin
               nib_ok = 1'b0;
            end
            if (!nib_ok) begin
               emit_status(ST_BADHEX);
            end else begin
               hex_accum = {hex_accum[11:0], nib};
               if (hex_digits_seen == 2'd3) begin
                  hex_digits_seen = '0;
                  scan_phase      = PH_BODY;
                  // encode the code point as UTF-8 of one to three bytes
                  if (hex_accum <= 16'h007F) begin
                     emit_byte(hex_accum[7:0]);
                  end else if (hex_accum <= 16'h07FF) begin
                     emit_byte({3'b110, hex_accum[10:6]});
                     emit_byte({2'b10, hex_accum[5:0]});
                  end else begin
                     emit_byte({4'b1110, hex_accum[15:12]});
                     emit_byte({2'b10, hex_accum[11:6]});
                     emit_byte({2'b10, hex_accum[5:0]});
                  end
               end else begin
                  hex_digits_seen = hex_digits_seen + 2'd1;
               end
            end
         end
         default: begin
            // done and unused phases drop the word
         end
      endcase

      // end of buffer: report a string left open or never opened, then start over
      if (w.is_final) begin
         if (scan_phase == PH_SEEK) begin
            emit_status(ST_NOQUOTE);
         end else if (scan_phase == PH_BODY || scan_phase == PH_ESC ||
                      scan_phase == PH_HEX) begin
            emit_status(ST_UNTERM);
         end
         clear_scan();
      end

      // flag the last result of this word
      if (word_results.size() != 0) begin
         r         = word_results[word_results.size() - 1];
         r.run_end = 1'b1;
         word_results[word_results.size() - 1] = r;
      end
      foreach (word_results[i]) decoded_rsp.insert(decoded_rsp.size(), word_results[i]);
   endtask

   // watch both channels: predict on accepted input, compare accepted output
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         clear_scan();
         decoded_rsp.delete();
      end else begin
         if (req_valid && !req_stall) begin
            unescape_word(req_word);
         end
         if (rsp_valid && !rsp_stall) begin
            if (decoded_rsp.size() == 0) begin
               $error("result word %h arrived with nothing expected", rsp_word);
               mismatches++;
            end else begin
               want = decoded_rsp.pop_front();
               if (rsp_word.out_byte !== want.out_byte) begin
                  $error("out_byte expected %h got %h", want.out_byte, rsp_word.out_byte);
                  mismatches++;
               end
               if (rsp_word.is_status !== want.is_status) begin
                  $error("is_status expected %h got %h", want.is_status, rsp_word.is_status);
                  mismatches++;
               end
               if (rsp_word.status_code !== want.status_code) begin
                  $error("status_code expected %h got %h",
                         want.status_code, rsp_word.status_code);
                  mismatches++;
               end
               if (rsp_word.run_end !== want.run_end) begin
                  $error("run_end expected %h got %h", want.run_end, rsp_word.run_end);
                  mismatches++;
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= decoded_rsp.size();
   end

endmodule

>>> test/tb_quoted_string_unescape_utf8_unit.sv
`timescale 1ns / 100ps
module tb_quoted_string_unescape_utf8_unit;
   import qsu_pkg::*;

   localparam int unsigned STREAM_LEN     = 405;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned DRAIN_CYCLES   = 16;

   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VTAB    = 8'h0B;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_DIGIT0  = 8'h30;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOW_Q   = 8'h71;
   localparam logic [7:0] CH_LOW_X   = 8'h78;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int unsigned  fail_count;
   int unsigned  pending_count;
   int unsigned  idle_cycles = 0;
   int unsigned  rsp_hold    = 0;

   req_word_type text_stream[$];

   wire req_fire = req_valid && !req_stall;
   wire rsp_fire = rsp_valid && !rsp_stall;

   always #5 clock = ~clock;

   quoted_string_unescape_utf8_unit i_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_word,
      .rsp_valid,
      .rsp_stall,
      .rsp_word
   );

   quoted_string_unescape_checker i_checker (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_word,
      .rsp_valid,
      .rsp_stall,
      .rsp_word,
      .fail_count,
      .pending_count
   );

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] pick_space();
      if ($urandom_range(0, 5) == 0) return CH_SPACE;
      return CH_TAB + 8'($urandom_range(0, 4));
   endfunction

   // small, two-byte and three-byte ranges, plus the encoding boundaries
   function automatic logic [15:0] pick_code_point();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 16'h007F));
         1: return 16'($urandom_range(16'h0080, 16'h07FF));
         2: return 16'($urandom_range(16'h0800, 16'hFFFF));
         default: begin
            case ($urandom_range(0, 5))
               0: return 16'h0000;
               1: return 16'h007F;
               2: return 16'h0080;
               3: return 16'h07FF;
               4: return 16'h0800;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   task automatic push_word(input logic [7:0] b);
      req_word_type w;
      w.data_byte = b;
      w.is_final  = 1'b0;
      text_stream.insert(text_stream.size(), w);
   endtask

   task automatic mark_final();
      req_word_type w;
      w          = text_stream[text_stream.size() - 1];
      w.is_final = 1'b1;
      text_stream[text_stream.size() - 1] = w;
   endtask

   // leading hex digits of a code point, each in random case
   task automatic push_hex(input logic [15:0] cp, input int unsigned count);
      logic [3:0] nib;
      for (int k = 0; k < count; k++) begin
         nib = cp[15 - 4 * k -: 4];
         if (nib < 4'd10) begin
            push_word(CH_DIGIT0 + 8'(nib));
         end else begin
            push_word(($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(nib) - 8'd10);
         end
      end
   endtask

   task automatic push_trailer();
      repeat ($urandom_range(0, 2)) push_word(8'($urandom));
   endtask

   task automatic push_open(output logic [7:0] q);
      repeat ($urandom_range(0, 2)) push_word(pick_space());
      q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
      push_word(q);
   endtask

   // one element of a string body: plain byte, simple escape or \u escape
   task automatic push_body_elem(input logic [7:0] q);
      logic [7:0]  b;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         b = 8'($urandom);
         // keep a plain byte from closing or escaping: use the other quote kind
         if (b == CH_BSLASH || b == q) b = (q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE;
         push_word(b);
      end else if (r < 75) begin
         push_word(CH_BSLASH);
         case ($urandom_range(0, 8))
            0: push_word(CH_DQUOTE);
            1: push_word(CH_SQUOTE);
            2: push_word(CH_BSLASH);
            3: push_word(CH_SLASH);
            4: push_word(CH_LOW_B);
            5: push_word(CH_LOW_F);
            6: push_word(CH_LOW_N);
            7: push_word(CH_LOW_R);
            default: push_word(CH_LOW_T);
         endcase
      end else begin
         push_word(CH_BSLASH);
         push_word(CH_LOW_U);
         push_hex(pick_code_point(), 4);
      end
   endtask

   // one buffer: mostly well-formed strings, the rest broken or noise
   task automatic add_random_string();
      logic [7:0]  q;
      logic [7:0]  b;
      int unsigned kind;
      kind = $urandom_range(0, 99);
      if (kind < 90) begin
         push_open(q);
         repeat ($urandom_range(0, 6)) push_body_elem(q);
      end
      if (kind < 70) begin
         push_word(q);
         push_trailer();
      end else if (kind < 78) begin
         // cut short in the body, after a backslash or inside the hex digits
         case ($urandom_range(0, 2))
            0: begin
            end
            1: push_word(CH_BSLASH);
            default: begin
               push_word(CH_BSLASH);
               push_word(CH_LOW_U);
               push_hex(pick_code_point(), $urandom_range(0, 3));
            end
         endcase
      end else if (kind < 84) begin
         // unknown escape letter
         push_word(CH_BSLASH);
         b = 8'($urandom);
         if (b == CH_DQUOTE || b == CH_SQUOTE || b == CH_BSLASH || b == CH_SLASH ||
             b == CH_LOW_B || b == CH_LOW_F || b == CH_LOW_N || b == CH_LOW_R ||
             b == CH_LOW_T || b == CH_LOW_U) begin
            b = CH_LOW_Q;
         end
         push_word(b);
         push_trailer();
      end else if (kind < 90) begin
         // non-hex byte among the digits of \u
         push_word(CH_BSLASH);
         push_word(CH_LOW_U);
         push_hex(pick_code_point(), $urandom_range(0, 3));
         case ($urandom_range(0, 3))
            0: b = 8'($urandom_range(8'h00, 8'h2F));
            1: b = 8'($urandom_range(8'h3A, 8'h40));
            2: b = 8'($urandom_range(8'h47, 8'h60));
            default: b = 8'($urandom_range(8'h67, 8'hFF));
         endcase
         push_word(b);
         push_trailer();
      end else if (kind < 95) begin
         // no opening quote
         repeat ($urandom_range(0, 2)) push_word(pick_space());
         b = 8'($urandom);
         if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR) || b == CH_SQUOTE ||
             b == CH_DQUOTE) begin
            b = CH_LOW_X;
         end
         push_word(b);
         push_trailer();
      end else begin
         repeat ($urandom_range(1, 4)) push_word(8'($urandom));
      end
      mark_final();
   endtask

   // stall the result side in segments, with long calm stretches now and then
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b1;
         rsp_hold  <= pick_gap();
      end
   end

   // end the run when no word moves on either channel for too long
   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("tb_quoted_string_unescape_utf8_unit NOT OK");
         $finish;
      end
   end

   initial begin
      int unsigned gap;

      // whitespace, single quote, extreme bytes, other quote kind, widest \u,
      // string closed by the final word
      push_word(CH_SPACE);
      push_word(CH_VTAB);
      push_word(CH_SQUOTE);
      push_word(8'h00);
      push_word(8'hFF);
      push_word(CH_DQUOTE);
      push_word(CH_BSLASH);
      push_word(CH_LOW_U);
      push_hex(16'hFFFF, 4);
      push_word(CH_SQUOTE);
      mark_final();
      // byte before any quote, then an ignored final word
      push_word(CH_LOW_X);
      push_word(CH_UPPER_A);
      mark_final();
      // buffer ends before the quote
      push_word(CH_TAB);
      mark_final();
      // three-byte escape on the final word: four results at once
      push_word(CH_DQUOTE);
      push_word(CH_BSLASH);
      push_word(CH_LOW_U);
      push_word("a");
      push_word("B");
      push_word("c");
      push_word("D");
      mark_final();
      // unknown escape letter
      push_word(CH_DQUOTE);
      push_word(CH_BSLASH);
      push_word(CH_LOW_Q);
      push_word(8'h00);
      mark_final();

      while (text_stream.size() < STREAM_LEN) add_random_string();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // drive each word and hold it until accepted
      foreach (text_stream[i]) begin
         gap = (i % 100 < 20) ? 0 : pick_gap();
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_word  <= text_stream[i];
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      req_valid <= 1'b0;

      // drain the remaining results, then give stray words time to show up
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_quoted_string_unescape_utf8_unit OK");
      end else begin
         $display("tb_quoted_string_unescape_utf8_unit NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/qsu_pkg.sv
design/qsu_front.sv
design/qsu_queue.sv
design/qsu_back.sv
design/quoted_string_unescape_utf8_unit.sv
test/quoted_string_unescape_checker.sv
test/tb_quoted_string_unescape_utf8_unit.sv
